[hw/rtl/hrtm_pkg.sv]
// ----------------------------------------------------------------------------
// hrtm_pkg
// Types, constants and the popcount helper shared by the Hamming ratio-test
// matcher.
// ----------------------------------------------------------------------------
package hrtm_pkg;

  localparam int DESC_W    = 64;
  localparam int FEAT_W    = 11;
  localparam int FEAT_SPAN = 2048;
  localparam int TAG_W     = 16;
  localparam int DIST_W    = 9;
  localparam int CNT_W     = 12;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 1;
  localparam int Q_DEPTH   = 4;
  localparam int Q_AW      = 2;

  localparam logic [DIST_W-1:0]    DIST_NONE  = 9'd256;
  localparam logic [CNT_W-1:0]     CNT_MAX    = 12'd4095;
  localparam logic [CFG_W-1:0]     THRESH_RST = 9'd50;
  localparam logic [CFG_W-1:0]     RATIO_RST  = 9'd154;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NN_RATIO        = 1'b1;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_BEGIN = 2'd1,
    CMD_CAND  = 2'd2,
    CMD_MARK  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [FEAT_W-1:0] feat;
    logic              last;
    logic [DIST_W-1:0] ham_dist;
    logic [TAG_W-1:0]  tag;
  } qent_t;

  typedef struct packed {
    logic push;
    logic pop;
  } qctl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qsts_t;

  function automatic logic [6:0] popcnt64(input logic [DESC_W-1:0] v);
    logic [DESC_W-1:0] a;
    logic [DESC_W-1:0] b;
    logic [DESC_W-1:0] c;
    logic [6:0]        s;
    a = v - ((v >> 1) & 64'h5555_5555_5555_5555);
    b = (a & 64'h3333_3333_3333_3333) + ((a >> 2) & 64'h3333_3333_3333_3333);
    c = (b + (b >> 4)) & 64'h0F0F_0F0F_0F0F_0F0F;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + 7'(c[8*i +: 8]);
    end
    return s;
  endfunction

endpackage

[hw/rtl/hrtm_front.sv]
// ----------------------------------------------------------------------------
// hrtm_front
// Accepts items, holds the query descriptor and takes the Hamming distance
// of every item against it before queueing.
// ----------------------------------------------------------------------------
module hrtm_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_command,
  input  logic [hrtm_pkg::DESC_W-1:0]  in_desc_w0,
  input  logic [hrtm_pkg::DESC_W-1:0]  in_desc_w1,
  input  logic [hrtm_pkg::DESC_W-1:0]  in_desc_w2,
  input  logic [hrtm_pkg::DESC_W-1:0]  in_desc_w3,
  input  logic [hrtm_pkg::FEAT_W-1:0]  in_feature_index,
  input  logic [hrtm_pkg::TAG_W-1:0]   in_query_tag,
  input  logic                         in_is_last,
  input  hrtm_pkg::qsts_t              q_sts,
  input  logic                         map_busy,
  output logic                         q_push,
  output hrtm_pkg::qent_t              q_wdata
);
  import hrtm_pkg::*;

  logic [DESC_W-1:0] query_r [4];
  logic              accept;
  logic [DIST_W-1:0] ham_dist;

  assign in_stall = q_sts.full || map_busy;
  assign accept   = in_valid && !in_stall;

  assign ham_dist = 9'(popcnt64(query_r[0] ^ in_desc_w0))
                  + 9'(popcnt64(query_r[1] ^ in_desc_w1))
                  + 9'(popcnt64(query_r[2] ^ in_desc_w2))
                  + 9'(popcnt64(query_r[3] ^ in_desc_w3));

  assign q_push           = accept;
  assign q_wdata.cmd      = cmd_t'(in_command);
  assign q_wdata.feat     = in_feature_index;
  assign q_wdata.last     = in_is_last;
  assign q_wdata.ham_dist = ham_dist;
  assign q_wdata.tag      = in_query_tag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < 4; w++) begin
        query_r[w] <= '0;
      end
    end else if (accept && cmd_t'(in_command) == CMD_BEGIN) begin
      query_r[0] <= in_desc_w0;
      query_r[1] <= in_desc_w1;
      query_r[2] <= in_desc_w2;
      query_r[3] <= in_desc_w3;
    end
  end

endmodule

[hw/rtl/hrtm_queue.sv]
// ----------------------------------------------------------------------------
// hrtm_queue
// Short FIFO between the distance front and the matching back.
// ----------------------------------------------------------------------------
module hrtm_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  hrtm_pkg::qctl_t q_ctl,
  input  hrtm_pkg::qent_t q_wdata,
  output hrtm_pkg::qsts_t q_sts,
  output hrtm_pkg::qent_t q_head
);
  import hrtm_pkg::*;

  qent_t             fifo_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r;
  logic [Q_AW-1:0]   rd_ptr_r;
  logic [Q_AW:0]     count_r;
  logic [Q_AW:0]     count_nxt;
  logic              do_push;
  logic              do_pop;

  assign q_sts.full  = (count_r == (Q_AW+1)'(Q_DEPTH));
  assign q_sts.empty = (count_r == '0);
  assign q_head      = fifo_r[rd_ptr_r];
  assign do_push     = q_ctl.push && !q_sts.full;
  assign do_pop      = q_ctl.pop && !q_sts.empty;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      fifo_r[wr_ptr_r] <= q_wdata;
    end
  end

endmodule

[hw/rtl/hrtm_back.sv]
// ----------------------------------------------------------------------------
// hrtm_back
// Tracks best and second-best distance, holds the matched-feature map,
// applies the threshold and ratio tests and drives the result register.
// ----------------------------------------------------------------------------
module hrtm_back #(
  parameter int MAX_FEATURES = 2048
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  hrtm_pkg::qent_t             q_head,
  input  hrtm_pkg::qsts_t             q_sts,
  output logic                        q_pop,
  output logic                        map_busy,
  input  logic [hrtm_pkg::CFG_W-1:0]  match_threshold,
  input  logic [hrtm_pkg::CFG_W-1:0]  nn_ratio,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [hrtm_pkg::TAG_W-1:0]  out_result_tag,
  output logic                        out_match_found,
  output logic [hrtm_pkg::FEAT_W-1:0] out_match_feature,
  output logic [hrtm_pkg::DIST_W-1:0] out_nearest_distance,
  output logic [hrtm_pkg::DIST_W-1:0] out_second_distance,
  output logic                        out_second_present,
  output logic [hrtm_pkg::CNT_W-1:0]  out_frame_match_count
);
  import hrtm_pkg::*;

  localparam int MAP_DEPTH = (MAX_FEATURES < FEAT_SPAN) ? MAX_FEATURES : FEAT_SPAN;
  localparam int AW        = $clog2(MAP_DEPTH);
  localparam logic [FEAT_W:0] MAP_LIMIT = (FEAT_W+1)'(MAP_DEPTH);
  localparam logic [AW-1:0]   CLR_LAST  = AW'(MAP_DEPTH - 1);

  logic              map_mem_r [MAP_DEPTH];
  logic              clr_active_r;
  logic [AW-1:0]     clr_addr_r;

  logic              p_valid_r;
  qent_t             p_ent_r;
  logic              p_mapbit_r;
  logic              p_hit_r;

  logic [DIST_W-1:0] best_r,  best_nxt;
  logic [DIST_W-1:0] second_r, second_nxt;
  logic              has_best_r, has_best_nxt;
  logic              has_second_r, has_second_nxt;
  logic [FEAT_W-1:0] best_feat_r, best_feat_nxt;
  logic              best_marked_r, best_marked_nxt;
  logic [TAG_W-1:0]  tag_r, tag_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [TAG_W-1:0]  out_tag_r;
  logic              out_found_r;
  logic [FEAT_W-1:0] out_feat_r;
  logic [DIST_W-1:0] out_best_r;
  logic [DIST_W-1:0] out_second_r;
  logic              out_has_second_r;
  logic [CNT_W-1:0]  out_count_r;

  logic              feat_ok;
  logic              cand_skip;
  logic              take_best;
  logic              close;
  logic              found;
  logic              clr_start;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic              p_advance;
  logic              out_free;
  logic [AW-1:0]     rd_addr;
  logic [2*CFG_W-1:0] ratio_prod;
  logic [2*CFG_W-1:0] best_scaled;

  assign feat_ok   = ({1'b0, p_ent_r.feat} < MAP_LIMIT);
  assign cand_skip = !feat_ok || p_mapbit_r || p_hit_r;
  assign take_best = !has_best_r || (p_ent_r.ham_dist < best_r);

  always_comb begin
    best_nxt        = best_r;
    second_nxt      = second_r;
    has_best_nxt    = has_best_r;
    has_second_nxt  = has_second_r;
    best_feat_nxt   = best_feat_r;
    best_marked_nxt = best_marked_r;
    tag_nxt         = tag_r;
    count_nxt       = count_r;
    wr_en           = 1'b0;
    wr_addr         = p_ent_r.feat[AW-1:0];
    close           = 1'b0;
    clr_start       = 1'b0;
    if (p_valid_r) begin
      unique case (p_ent_r.cmd)
        CMD_CLEAR: begin
          count_nxt       = '0;
          best_marked_nxt = 1'b0;
          clr_start       = 1'b1;
        end
        CMD_MARK: begin
          if (feat_ok) begin
            wr_en = 1'b1;
            if (p_ent_r.feat == best_feat_r) begin
              best_marked_nxt = 1'b1;
            end
          end
        end
        CMD_BEGIN: begin
          tag_nxt         = p_ent_r.tag;
          best_nxt        = DIST_NONE;
          second_nxt      = DIST_NONE;
          has_best_nxt    = 1'b0;
          has_second_nxt  = 1'b0;
          best_feat_nxt   = '0;
          best_marked_nxt = 1'b0;
          close           = p_ent_r.last;
        end
        CMD_CAND: begin
          if (!cand_skip) begin
            if (take_best) begin
              if (has_best_r) begin
                second_nxt     = best_r;
                has_second_nxt = 1'b1;
              end
              best_nxt        = p_ent_r.ham_dist;
              has_best_nxt    = 1'b1;
              best_feat_nxt   = p_ent_r.feat;
              best_marked_nxt = 1'b0;
            end else if (!has_second_r || p_ent_r.ham_dist < second_r) begin
              second_nxt     = p_ent_r.ham_dist;
              has_second_nxt = 1'b1;
            end
          end
          close = p_ent_r.last;
        end
        default: ;
      endcase
    end
    ratio_prod  = {9'b0, nn_ratio} * {9'b0, second_nxt};
    best_scaled = {1'b0, best_nxt, 8'h00};
    found = has_best_nxt && (best_nxt <= match_threshold)
         && (!has_second_nxt || (best_scaled < ratio_prod));
    if (close && found && !best_marked_nxt) begin
      wr_en   = 1'b1;
      wr_addr = best_feat_nxt[AW-1:0];
      if (count_r != CNT_MAX) begin
        count_nxt = count_r + 1'b1;
      end
    end
  end

  assign out_free  = !out_valid_r || !out_stall;
  assign p_advance = p_valid_r && (!close || out_free);
  assign rd_addr   = q_head.feat[AW-1:0];
  assign q_pop     = !q_sts.empty && !clr_active_r
                  && !(p_valid_r && p_ent_r.cmd == CMD_CLEAR)
                  && (!p_valid_r || p_advance);
  assign map_busy  = clr_active_r;

  assign out_valid_nxt = (p_advance && close) ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r  <= 1'b1;
      clr_addr_r    <= '0;
      p_valid_r     <= 1'b0;
      p_hit_r       <= 1'b0;
      best_r        <= DIST_NONE;
      second_r      <= DIST_NONE;
      has_best_r    <= 1'b0;
      has_second_r  <= 1'b0;
      best_feat_r   <= '0;
      best_marked_r <= 1'b0;
      tag_r         <= '0;
      count_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (clr_active_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == CLR_LAST) begin
          clr_active_r <= 1'b0;
        end
      end else if (p_advance && clr_start) begin
        clr_active_r <= 1'b1;
        clr_addr_r   <= '0;
      end
      if (q_pop) begin
        p_valid_r <= 1'b1;
        p_hit_r   <= p_advance && wr_en && (wr_addr == rd_addr);
      end else if (p_advance) begin
        p_valid_r <= 1'b0;
      end
      if (p_advance) begin
        tag_r     <= tag_nxt;
        count_r   <= count_nxt;
        if (close) begin
          best_r        <= DIST_NONE;
          second_r      <= DIST_NONE;
          has_best_r    <= 1'b0;
          has_second_r  <= 1'b0;
          best_feat_r   <= '0;
          best_marked_r <= 1'b0;
        end else begin
          best_r        <= best_nxt;
          second_r      <= second_nxt;
          has_best_r    <= has_best_nxt;
          has_second_r  <= has_second_nxt;
          best_feat_r   <= best_feat_nxt;
          best_marked_r <= best_marked_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      p_ent_r <= q_head;
    end
    if (p_advance && close) begin
      out_tag_r        <= tag_nxt;
      out_found_r      <= found;
      out_feat_r       <= best_feat_nxt;
      out_best_r       <= best_nxt;
      out_second_r     <= second_nxt;
      out_has_second_r <= has_second_nxt;
      out_count_r      <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_active_r) begin
      map_mem_r[clr_addr_r] <= 1'b0;
    end else if (p_advance && wr_en) begin
      map_mem_r[wr_addr] <= 1'b1;
    end
    if (q_pop) begin
      p_mapbit_r <= map_mem_r[rd_addr];
    end
  end

  assign out_valid             = out_valid_r;
  assign out_result_tag        = out_tag_r;
  assign out_match_found       = out_found_r;
  assign out_match_feature     = out_feat_r;
  assign out_nearest_distance  = out_best_r;
  assign out_second_distance   = out_second_r;
  assign out_second_present    = out_has_second_r;
  assign out_frame_match_count = out_count_r;

  a_no_map_write_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> !(p_advance && wr_en))
    else $error("map written during clearing pass");

  a_second_needs_best: assert property (@(posedge clk) disable iff (!rst_n)
    has_second_r |-> (has_best_r && best_r <= second_r))
    else $error("second best present without a better best");

  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    !(p_advance && p_ent_r.cmd == CMD_CLEAR) |=> count_r >= $past(count_r))
    else $error("match count dropped without a frame clear");

  a_no_pop_behind_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (p_valid_r && p_ent_r.cmd == CMD_CLEAR) |=> !p_valid_r && clr_active_r)
    else $error("item followed a frame clear before the clearing pass");

endmodule

[hw/rtl/hamming_ratio_test_matcher_top.sv]
// ----------------------------------------------------------------------------
// hamming_ratio_test_matcher_top
// Hamming nearest-neighbour matcher for 256-bit descriptors with ratio test.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  command, desc words, feature, tag
//   out_     output     out_valid/out_stall  match result of a closed run
//   cfg_     input      cfg_we               threshold and ratio registers
//
// One item per cycle while in_stall is low; the distance popcount sits in
// the front, the run update and tests in the back, with a four-entry queue
// between them. A closing item passes the queue and the back's item
// register before its result is registered. After reset and each clear-frame
// item the min(MAX_FEATURES, 2048)-entry matched-feature map is swept one
// entry a cycle, in_stall high meanwhile; result stalls back up via the queue to in_stall.
// ----------------------------------------------------------------------------
module hamming_ratio_test_matcher_top #(
  parameter int MAX_FEATURES = 2048
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_command,
  input  logic [hrtm_pkg::DESC_W-1:0]     in_desc_w0,
  input  logic [hrtm_pkg::DESC_W-1:0]     in_desc_w1,
  input  logic [hrtm_pkg::DESC_W-1:0]     in_desc_w2,
  input  logic [hrtm_pkg::DESC_W-1:0]     in_desc_w3,
  input  logic [hrtm_pkg::FEAT_W-1:0]     in_feature_index,
  input  logic [hrtm_pkg::TAG_W-1:0]      in_query_tag,
  input  logic                            in_is_last,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [hrtm_pkg::TAG_W-1:0]      out_result_tag,
  output logic                            out_match_found,
  output logic [hrtm_pkg::FEAT_W-1:0]     out_match_feature,
  output logic [hrtm_pkg::DIST_W-1:0]     out_nearest_distance,
  output logic [hrtm_pkg::DIST_W-1:0]     out_second_distance,
  output logic                            out_second_present,
  output logic [hrtm_pkg::CNT_W-1:0]      out_frame_match_count,
  input  logic                            cfg_we,
  input  logic [hrtm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hrtm_pkg::CFG_W-1:0]      cfg_wdata
);
  import hrtm_pkg::*;

  logic [CFG_W-1:0] thresh_r;
  logic [CFG_W-1:0] ratio_r;
  qctl_t            q_ctl;
  qsts_t            q_sts;
  qent_t            q_wdata;
  qent_t            q_head;
  logic             q_push;
  logic             q_pop;
  logic             map_busy;

  assign q_ctl = '{push: q_push, pop: q_pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RST;
      ratio_r  <= RATIO_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MATCH_THRESHOLD: thresh_r <= cfg_wdata;
        REG_NN_RATIO:        ratio_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  hrtm_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_desc_w0       (in_desc_w0),
    .in_desc_w1       (in_desc_w1),
    .in_desc_w2       (in_desc_w2),
    .in_desc_w3       (in_desc_w3),
    .in_feature_index (in_feature_index),
    .in_query_tag     (in_query_tag),
    .in_is_last       (in_is_last),
    .q_sts            (q_sts),
    .map_busy         (map_busy),
    .q_push           (q_push),
    .q_wdata          (q_wdata)
  );

  hrtm_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_ctl   (q_ctl),
    .q_wdata (q_wdata),
    .q_sts   (q_sts),
    .q_head  (q_head)
  );

  hrtm_back #(
    .MAX_FEATURES (MAX_FEATURES)
  ) u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_head                (q_head),
    .q_sts                 (q_sts),
    .q_pop                 (q_pop),
    .map_busy              (map_busy),
    .match_threshold       (thresh_r),
    .nn_ratio              (ratio_r),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_result_tag        (out_result_tag),
    .out_match_found       (out_match_found),
    .out_match_feature     (out_match_feature),
    .out_nearest_distance  (out_nearest_distance),
    .out_second_distance   (out_second_distance),
    .out_second_present    (out_second_present),
    .out_frame_match_count (out_frame_match_count)
  );

endmodule

[test/hamming_ratio_test_matcher_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hamming_ratio_test_matcher_top_tb
// Self-checking bench for the Hamming ratio-test matcher. A queue-fed driver
// offers clear, begin, candidate and mark items, with random gaps. A
// clocked monitor keeps its own model of query, run, feature map and count,
// predicts each closed run and compares every result field. Threshold and
// ratio are swept between phases, extremes included. Receiver stalls are
// random, with one long hold-off that backs the block up to its input.
// ----------------------------------------------------------------------------
module hamming_ratio_test_matcher_top_tb;

  import hrtm_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASE_ITEMS = 165;
  localparam int LONG_HOLD   = 300;

  typedef struct packed {
    cmd_t              cmd;
    logic [255:0]      desc;
    logic [FEAT_W-1:0] feat;
    logic [TAG_W-1:0]  tag;
    logic              last;
  } match_item_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic              found;
    logic [FEAT_W-1:0] feat;
    logic [DIST_W-1:0] nearest;
    logic [DIST_W-1:0] second_dist;
    logic              present;
    logic [CNT_W-1:0]  count;
  } match_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  cmd_t                  in_command = CMD_CLEAR;
  logic [255:0]          in_desc = '0;
  logic [FEAT_W-1:0]     in_feature_index = '0;
  logic [TAG_W-1:0]      in_query_tag = '0;
  logic                  in_is_last = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [TAG_W-1:0]      out_result_tag;
  logic                  out_match_found;
  logic [FEAT_W-1:0]     out_match_feature;
  logic [DIST_W-1:0]     out_nearest_distance;
  logic [DIST_W-1:0]     out_second_distance;
  logic                  out_second_present;
  logic [CNT_W-1:0]      out_frame_match_count;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_wdata = '0;

  match_item_t   pending_items[$];
  match_result_t expected_results[$];
  match_item_t   next_item;
  match_result_t result_head;

  int            items_queued = 0;
  int            items_accepted = 0;
  int            results_seen = 0;
  int            mismatch_count = 0;
  int            cycle_count = 0;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  int            send_gap = 0;
  int            recv_gap = 0;
  int            hold_left = 0;
  bit            hold_done = 1'b0;
  logic          in_fire = 1'b0;

  // matcher model state
  logic [CFG_W-1:0]  thr_reg = THRESH_RST;
  logic [CFG_W-1:0]  ratio_reg = RATIO_RST;
  logic [255:0]      query_desc = '0;
  logic [TAG_W-1:0]  query_tag = '0;
  logic [DIST_W-1:0] run_best = DIST_NONE;
  logic [DIST_W-1:0] run_second = DIST_NONE;
  bit                run_has_best = 1'b0;
  bit                run_has_second = 1'b0;
  logic [FEAT_W-1:0] run_best_feat = '0;
  bit                feat_matched[FEAT_SPAN];
  logic [CNT_W-1:0]  frame_count = '0;

  logic [255:0]      gen_query = '0;

  hamming_ratio_test_matcher_top u_top (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_command            (in_command),
    .in_desc_w0            (in_desc[63:0]),
    .in_desc_w1            (in_desc[127:64]),
    .in_desc_w2            (in_desc[191:128]),
    .in_desc_w3            (in_desc[255:192]),
    .in_feature_index      (in_feature_index),
    .in_query_tag          (in_query_tag),
    .in_is_last            (in_is_last),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_result_tag        (out_result_tag),
    .out_match_found       (out_match_found),
    .out_match_feature     (out_match_feature),
    .out_nearest_distance  (out_nearest_distance),
    .out_second_distance   (out_second_distance),
    .out_second_present    (out_second_present),
    .out_frame_match_count (out_frame_match_count),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- model
  task automatic close_query_run();
    match_result_t r;
    bit            found;
    found = 1'b0;
    if (run_has_best && run_best <= thr_reg) begin
      if (!run_has_second ||
          (int'(run_best) * 256 < int'(ratio_reg) * int'(run_second)))
        found = 1'b1;
    end
    if (found && !feat_matched[run_best_feat]) begin
      feat_matched[run_best_feat] = 1'b1;
      if (frame_count != CNT_MAX)
        frame_count = frame_count + 1'b1;
    end
    r.tag         = query_tag;
    r.found       = found;
    r.feat        = run_best_feat;
    r.nearest     = run_best;
    r.second_dist = run_second;
    r.present     = run_has_second;
    r.count       = frame_count;
    expected_results.push_back(r);
    run_best       = DIST_NONE;
    run_second     = DIST_NONE;
    run_has_best   = 1'b0;
    run_has_second = 1'b0;
    run_best_feat  = '0;
  endtask

  task automatic predict_match_item(cmd_t cmd, logic [255:0] desc,
                                    logic [FEAT_W-1:0] feat,
                                    logic [TAG_W-1:0] tag, logic last);
    logic [DIST_W-1:0] ham_dist;
    case (cmd)
      CMD_CLEAR: begin
        foreach (feat_matched[i]) feat_matched[i] = 1'b0;
        frame_count = '0;
      end
      CMD_MARK: begin
        feat_matched[feat] = 1'b1;
      end
      CMD_BEGIN: begin
        query_desc     = desc;
        query_tag      = tag;
        run_best       = DIST_NONE;
        run_second     = DIST_NONE;
        run_has_best   = 1'b0;
        run_has_second = 1'b0;
        run_best_feat  = '0;
        if (last) close_query_run();
      end
      CMD_CAND: begin
        if (!feat_matched[feat]) begin
          ham_dist = DIST_W'($countones(query_desc ^ desc));
          if (!run_has_best || ham_dist < run_best) begin
            if (run_has_best) begin
              run_second     = run_best;
              run_has_second = 1'b1;
            end
            run_best      = ham_dist;
            run_has_best  = 1'b1;
            run_best_feat = feat;
          end else if (!run_has_second || ham_dist < run_second) begin
            run_second     = ham_dist;
            run_has_second = 1'b1;
          end
        end
        if (last) close_query_run();
      end
    endcase
  endtask

  task automatic check_field(string label, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, label, want, got);
      mismatch_count++;
    end
  endtask

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin
    in_fire <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_match_item(in_command, in_desc, in_feature_index, in_query_tag,
                           in_is_last);
        items_accepted++;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_MATCH_THRESHOLD: thr_reg = cfg_wdata;
          REG_NN_RATIO:        ratio_reg = cfg_wdata;
        endcase
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t ns: result with tag %0d arrived, none expected",
                   $time, out_result_tag);
          mismatch_count++;
        end else begin
          result_head = expected_results.pop_front();
          check_field("result_tag", 32'(result_head.tag), 32'(out_result_tag));
          check_field("match_found", 32'(result_head.found), 32'(out_match_found));
          check_field("match_feature", 32'(result_head.feat), 32'(out_match_feature));
          check_field("nearest_distance", 32'(result_head.nearest),
                      32'(out_nearest_distance));
          check_field("second_distance", 32'(result_head.second_dist),
                      32'(out_second_distance));
          check_field("second_present", 32'(result_head.present),
                      32'(out_second_present));
          check_field("frame_match_count", 32'(result_head.count),
                      32'(out_frame_match_count));
        end
      end
    end
  end

  // ---------------------------------------------------------------- driver
  always @(negedge clk) begin
    if (rst_n && (in_fire || !in_valid)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_items.size() == 0) begin
        in_valid <= 1'b0;
      end else if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
        send_gap = $urandom_range(0, 10);
        in_valid <= 1'b0;
      end else begin
        next_item = pending_items.pop_front();
        in_command       <= next_item.cmd;
        in_desc          <= next_item.desc;
        in_feature_index <= next_item.feat;
        in_query_tag     <= next_item.tag;
        in_is_last       <= next_item.last;
        in_valid         <= 1'b1;
      end
    end
  end

  // hold off once for a long stretch so the block fills and stalls its input
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && results_seen >= 30) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_stall <= 1'b1;
    end else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
      recv_gap = $urandom_range(0, 10);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic logic [255:0] rand_desc();
    return {$urandom(), $urandom(), $urandom(), $urandom(),
            $urandom(), $urandom(), $urandom(), $urandom()};
  endfunction

  function automatic logic [255:0] flip_bits(logic [255:0] base, int k);
    logic [255:0] v;
    v = base;
    for (int i = 0; i < k; i++) v[$urandom_range(0, 255)] ^= 1'b1;
    return v;
  endfunction

  function automatic logic [255:0] low_ones(int k);
    logic [255:0] all_ones;
    all_ones = '1;
    return (k == 0) ? '0 : all_ones >> (256 - k);
  endfunction

  function automatic logic [FEAT_W-1:0] pick_feature();
    if ($urandom_range(0, 9) < 6) return FEAT_W'($urandom_range(0, 31));
    return FEAT_W'($urandom_range(0, FEAT_SPAN - 1));
  endfunction

  function automatic logic [255:0] near_desc();
    case ($urandom_range(0, 3))
      0: return flip_bits(gen_query, $urandom_range(0, 20));
      1: return flip_bits(gen_query, $urandom_range(0, 70));
      2: return flip_bits(gen_query, $urandom_range(100, 256));
      default: return rand_desc();
    endcase
  endfunction

  task automatic push_item(cmd_t cmd, logic [255:0] desc, logic [FEAT_W-1:0] feat,
                           logic [TAG_W-1:0] tag, logic last);
    match_item_t it;
    it.cmd  = cmd;
    it.desc = desc;
    it.feat = feat;
    it.tag  = tag;
    it.last = last;
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic wait_drained();
    while (items_accepted != items_queued || expected_results.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
    while (in_stall) @(negedge clk);
  endtask

  task automatic gen_query_runs(int n);
    int               start;
    int               ncand;
    int               pick;
    logic [FEAT_W-1:0] f;
    start = items_queued;
    while (items_queued - start < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        gen_query = rand_desc();
        push_item(CMD_BEGIN, gen_query, FEAT_W'($urandom()), TAG_W'($urandom()), 1'b0);
        ncand = $urandom_range(1, 8);
        for (int c = 0; c < ncand; c++) begin
          f = pick_feature();
          push_item(CMD_CAND, near_desc(), f, TAG_W'($urandom()), c == ncand - 1);
          if (c != ncand - 1 && $urandom_range(0, 19) == 0)
            push_item(CMD_MARK, rand_desc(), f, TAG_W'($urandom()),
                      1'($urandom_range(0, 1)));
        end
      end else if (pick < 78) begin
        gen_query = rand_desc();
        push_item(CMD_BEGIN, gen_query, FEAT_W'($urandom()), TAG_W'($urandom()), 1'b1);
      end else if (pick < 86) begin
        push_item(CMD_MARK, rand_desc(), pick_feature(), TAG_W'($urandom()),
                  1'($urandom_range(0, 1)));
      end else if (pick < 94) begin
        push_item(CMD_CAND, near_desc(), pick_feature(), TAG_W'($urandom()),
                  1'($urandom_range(0, 1)));
      end else if (pick < 97) begin
        gen_query = rand_desc();
        push_item(CMD_BEGIN, gen_query, FEAT_W'($urandom()), TAG_W'($urandom()), 1'b0);
        ncand = $urandom_range(0, 2);
        for (int c = 0; c < ncand; c++)
          push_item(CMD_CAND, near_desc(), pick_feature(), TAG_W'($urandom()), 1'b0);
      end else begin
        push_item(CMD_CLEAR, rand_desc(), FEAT_W'($urandom()), TAG_W'($urandom()),
                  1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    int unsigned thr_set[6];
    int unsigned ratio_set[6];
    int          send_set[6];
    int          recv_set[6];
    thr_set   = '{256, 0, 511, 100, 0, 50};
    ratio_set = '{256, 511, 0, 200, 0, 154};
    send_set  = '{0, 30, 15, 25, 10, 0};
    recv_set  = '{30, 0, 25, 15, 20, 0};
    thr_set[4]   = $urandom_range(0, 511);
    ratio_set[4] = $urandom_range(0, 511);

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 20;
    recv_idle_pct = 20;

    // directed runs, mostly against a zero query, with reset register values
    push_item(CMD_BEGIN, '1, '1, 16'hFFFF, 1'b1);
    push_item(CMD_BEGIN, '0, '0, 16'h0000, 1'b0);
    push_item(CMD_CAND, '0, FEAT_W'(FEAT_SPAN - 1), '0, 1'b0);
    push_item(CMD_CAND, '1, '0, '0, 1'b1);
    push_item(CMD_CAND, '0, FEAT_W'(FEAT_SPAN - 1), '1, 1'b1);
    push_item(CMD_BEGIN, '0, '0, 16'h5A5A, 1'b0);
    push_item(CMD_CAND, low_ones(10), 11'd5, '0, 1'b0);
    push_item(CMD_CAND, low_ones(10), 11'd6, '0, 1'b1);
    push_item(CMD_MARK, '0, 11'd7, '0, 1'b0);
    push_item(CMD_BEGIN, '0, '0, 16'd1, 1'b0);
    push_item(CMD_CAND, '0, 11'd7, '0, 1'b0);
    push_item(CMD_CAND, low_ones(20), 11'd8, '0, 1'b1);
    push_item(CMD_BEGIN, '0, '0, 16'd2, 1'b0);
    push_item(CMD_CAND, low_ones(5), 11'd9, '0, 1'b0);
    push_item(CMD_MARK, '0, 11'd9, '0, 1'b0);
    push_item(CMD_CAND, low_ones(200), 11'd10, '0, 1'b1);
    push_item(CMD_CLEAR, '0, '0, '0, 1'b0);
    push_item(CMD_CAND, low_ones(50), FEAT_W'(FEAT_SPAN - 1), '0, 1'b1);
    push_item(CMD_BEGIN, '0, '0, 16'd3, 1'b0);
    push_item(CMD_CAND, low_ones(51), 11'd100, '0, 1'b1);
    push_item(CMD_BEGIN, '0, '0, 16'd4, 1'b0);
    push_item(CMD_CAND, low_ones(30), 11'd101, '0, 1'b0);
    push_item(CMD_CAND, low_ones(49), 11'd102, '0, 1'b1);
    push_item(CMD_BEGIN, '0, '0, 16'd5, 1'b0);
    push_item(CMD_CAND, low_ones(30), 11'd103, '0, 1'b0);
    push_item(CMD_CAND, low_ones(50), 11'd104, '0, 1'b1);
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      write_reg(REG_MATCH_THRESHOLD, CFG_W'(thr_set[p]));
      write_reg(REG_NN_RATIO, CFG_W'(ratio_set[p]));
      send_idle_pct = send_set[p];
      recv_idle_pct = recv_set[p];
      gen_query_runs(PHASE_ITEMS);
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
